### src/assert_macros.svh
// Assertion macros shared by the position-correction RTL.
// Plain text macros, no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/cdpc_pkg.sv
// Package for capture DMA position correction: widths, register map,
// controller states, command/status structs, remainder step function.
package cdpc_pkg;

    localparam int unsigned DataW    = 32;
    localparam int unsigned FifoW    = 16;
    localparam int unsigned AddrW    = 4;
    localparam int unsigned RemIters = 16;   // two quotient bits per cycle
    localparam int unsigned RemCntW  = 4;

    localparam logic [DataW-1:0] RstPeriod = 32'd4096;
    localparam logic [DataW-1:0] RstBuffer = 32'd65536;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_PERIOD = 2'd1,
        REG_BUFFER = 2'd2,
        REG_FIFO   = 2'd3
    } t_reg_idx;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHK   = 7'b0000010,
        S_DMA   = 7'b0000100,
        S_ADJ   = 7'b0001000,
        S_LINK  = 7'b0010000,
        S_FINAL = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    typedef enum logic [1:0] {
        DV_NONE = 2'd0,
        DV_DMA  = 2'd1,
        DV_ADJ  = 2'd2,
        DV_LINK = 2'd3
    } t_div_sel;

    typedef enum logic [1:0] {
        OS_LINK = 2'd0,
        OS_ZERO = 2'd1,
        OS_SUM  = 2'd2
    } t_out_sel;

    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_src;
        t_div_sel cap;
        logic     bound_load;
        logic     out_load;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic link_le_fifo;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_sts;

    // One restoring remainder step. A zero divisor passes the dividend through.
    function automatic logic [DataW:0] rem_step(logic [DataW:0] r, logic bit_in,
                                                logic [DataW-1:0] d);
        logic [DataW:0] s;
        s = {r[DataW-1:0], bit_in};
        if (s >= {1'b0, d}) begin
            s = s - {1'b0, d};
        end
        return s;
    endfunction

endpackage

### src/cdpc_rem.sv
// Iterative 32-bit remainder unit, two bits per cycle.
// Depends on cdpc_pkg.
module cdpc_rem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [cdpc_pkg::DataW-1:0] i_dividend,
    input  logic [cdpc_pkg::DataW-1:0] i_divisor,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [cdpc_pkg::DataW-1:0] o_rem
);

    logic                        r_busy;
    logic                        r_done;
    logic [cdpc_pkg::RemCntW-1:0] r_cnt;
    logic [cdpc_pkg::DataW-1:0]   r_q;
    logic [cdpc_pkg::DataW:0]     r_r;
    logic [cdpc_pkg::DataW-1:0]   r_d;
    logic [cdpc_pkg::DataW:0]     n_r;
    logic                        last;

    assign n_r = cdpc_pkg::rem_step(
                     cdpc_pkg::rem_step(r_r, r_q[cdpc_pkg::DataW-1], r_d),
                     r_q[cdpc_pkg::DataW-2], r_d);
    assign last = (r_cnt == cdpc_pkg::RemCntW'(cdpc_pkg::RemIters - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[cdpc_pkg::DataW-3:0], 2'b00};
            r_r <= n_r;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_rem  = r_r[cdpc_pkg::DataW-1:0];

endmodule

### src/cdpc_dp.sv
// Datapath: operand registers, remainder unit, boundary logic, output register.
// Depends on cdpc_pkg and cdpc_rem.
module cdpc_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cdpc_pkg::t_cmd              i_cmd,
    input  logic [cdpc_pkg::DataW-1:0]  i_period,
    input  logic [cdpc_pkg::DataW-1:0]  i_buffer,
    input  logic [cdpc_pkg::FifoW-1:0]  i_fifo,
    input  logic [cdpc_pkg::DataW-1:0]  i_link_position,
    input  logic [cdpc_pkg::DataW-1:0]  i_dma_position,
    input  logic                        i_out_stall,
    output cdpc_pkg::t_sts              o_sts,
    output logic                        o_out_valid,
    output logic [cdpc_pkg::DataW-1:0]  o_corrected_position
);

    logic [cdpc_pkg::DataW-1:0] r_link;
    logic [cdpc_pkg::DataW-1:0] r_dma;
    logic [cdpc_pkg::DataW-1:0] r_adj;
    logic                       r_le;
    logic [cdpc_pkg::DataW-1:0] r_dma_off;
    logic [cdpc_pkg::DataW-1:0] r_adj_off;
    logic [cdpc_pkg::DataW-1:0] r_link_off;
    logic [cdpc_pkg::DataW-1:0] r_bound;
    logic                       r_out_valid;
    logic [cdpc_pkg::DataW-1:0] r_out;

    logic [cdpc_pkg::DataW-1:0] fifo_ext;
    logic                       in_le;
    logic [cdpc_pkg::DataW-1:0] div_in;
    logic                       div_busy;
    logic                       div_done;
    logic [cdpc_pkg::DataW-1:0] div_rem;
    logic [cdpc_pkg::DataW-1:0] adj_base;
    logic [cdpc_pkg::DataW-1:0] adj_next;
    logic [cdpc_pkg::DataW-1:0] n_bound;
    logic [cdpc_pkg::DataW-1:0] n_out;

    assign fifo_ext = {{(cdpc_pkg::DataW-cdpc_pkg::FifoW){1'b0}}, i_fifo};
    assign in_le    = (i_link_position <= fifo_ext);

    always_comb begin
        case (i_cmd.div_src)
            cdpc_pkg::DV_ADJ:  div_in = r_adj;
            cdpc_pkg::DV_LINK: div_in = r_link;
            default:           div_in = r_dma;
        endcase
    end

    cdpc_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_in),
        .i_divisor  (i_period),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign adj_base = r_adj - r_adj_off;
    assign adj_next = adj_base + i_period;

    always_comb begin
        if (r_link_off >= fifo_ext) begin
            n_bound = r_link - r_link_off;
        end else if (r_dma_off >= r_adj_off) begin
            n_bound = adj_base;
        end else if (adj_next >= i_buffer) begin
            n_bound = '0;
        end else begin
            n_bound = adj_next;
        end
    end

    always_comb begin
        case (i_cmd.out_sel)
            cdpc_pkg::OS_LINK: n_out = r_link;
            cdpc_pkg::OS_SUM:  n_out = r_bound + r_dma_off;
            default:           n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_link <= i_link_position;
            r_dma  <= i_dma_position;
            r_le   <= in_le;
            if (in_le) begin
                r_adj <= i_buffer + i_link_position - fifo_ext;
            end else begin
                r_adj <= i_link_position - fifo_ext;
            end
        end
        case (i_cmd.cap)
            cdpc_pkg::DV_DMA:  r_dma_off  <= div_rem;
            cdpc_pkg::DV_ADJ:  r_adj_off  <= div_rem;
            cdpc_pkg::DV_LINK: r_link_off <= div_rem;
            default: ;
        endcase
        if (i_cmd.bound_load) begin
            r_bound <= n_bound;
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.link_le_fifo = r_le;
    assign o_sts.div_busy     = div_busy;
    assign o_sts.div_done     = div_done;
    assign o_sts.out_free     = !r_out_valid || !i_out_stall;

    assign o_out_valid          = r_out_valid;
    assign o_corrected_position = r_out;

endmodule

### src/cdpc_ctrl.sv
// Controller state machine: sequences the three remainders (for corrected capture items) and the result.
// Depends on cdpc_pkg.
module cdpc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_capture_mode,
    input  logic           i_in_valid,
    input  cdpc_pkg::t_sts i_sts,
    output logic           o_in_stall,
    output cdpc_pkg::t_cmd o_cmd
);

    cdpc_pkg::t_state   r_state;
    cdpc_pkg::t_state   n_state;
    logic               r_startup;
    logic               n_startup;
    cdpc_pkg::t_out_sel r_out_sel;
    cdpc_pkg::t_out_sel n_out_sel;

    always_comb begin
        n_state   = r_state;
        n_startup = r_startup;
        n_out_sel = r_out_sel;
        o_cmd     = '0;
        o_cmd.out_sel = r_out_sel;
        case (r_state)
            cdpc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = cdpc_pkg::S_CHK;
                end
            end
            cdpc_pkg::S_CHK: begin
                if (!i_capture_mode) begin
                    n_out_sel = cdpc_pkg::OS_LINK;
                    n_state   = cdpc_pkg::S_OUT;
                end else if (r_startup && i_sts.link_le_fifo) begin
                    n_out_sel = cdpc_pkg::OS_ZERO;
                    n_state   = cdpc_pkg::S_OUT;
                end else begin
                    n_startup       = 1'b0;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = cdpc_pkg::DV_DMA;
                    n_state         = cdpc_pkg::S_DMA;
                end
            end
            cdpc_pkg::S_DMA: begin
                if (i_sts.div_done) begin
                    o_cmd.cap       = cdpc_pkg::DV_DMA;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = cdpc_pkg::DV_ADJ;
                    n_state         = cdpc_pkg::S_ADJ;
                end
            end
            cdpc_pkg::S_ADJ: begin
                if (i_sts.div_done) begin
                    o_cmd.cap       = cdpc_pkg::DV_ADJ;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = cdpc_pkg::DV_LINK;
                    n_state         = cdpc_pkg::S_LINK;
                end
            end
            cdpc_pkg::S_LINK: begin
                if (i_sts.div_done) begin
                    o_cmd.cap = cdpc_pkg::DV_LINK;
                    n_state   = cdpc_pkg::S_FINAL;
                end
            end
            cdpc_pkg::S_FINAL: begin
                o_cmd.bound_load = 1'b1;
                n_out_sel        = cdpc_pkg::OS_SUM;
                n_state          = cdpc_pkg::S_OUT;
            end
            cdpc_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = cdpc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cdpc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cdpc_pkg::S_IDLE;
            r_startup <= 1'b1;
            r_out_sel <= cdpc_pkg::OS_LINK;
        end else begin
            r_state   <= n_state;
            r_startup <= n_startup;
            r_out_sel <= n_out_sel;
        end
    end

    assign o_in_stall = (r_state != cdpc_pkg::S_IDLE);

endmodule

### src/capture_dma_position_correction_top.sv
// Capture DMA position correction, top level: APB registers, controller, datapath.
// Depends on cdpc_pkg, cdpc_ctrl, cdpc_dp and assert_macros.svh.
//
// One query item in, one corrected position out. Playback items, and capture
// items in the start-up window whose link position is at or below the FIFO
// level, go from accept through the check and output states to the result
// register. A corrected capture item runs three 32-bit remainders (DMA position,
// FIFO-adjusted link position, link position) one after another on a single
// remainder unit that retires two bits per cycle, then the boundary and output
// states. One item is in work at a time; a new item is taken as soon as its
// result is in the output register, even while that result is still stalled.
`include "assert_macros.svh"

module capture_dma_position_correction_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cdpc_pkg::AddrW-1:0]          paddr,
    input  logic [cdpc_pkg::DataW-1:0]          pwdata,
    output logic [cdpc_pkg::DataW-1:0]          prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [cdpc_pkg::DataW-1:0]          i_link_position,
    input  logic [cdpc_pkg::DataW-1:0]          i_dma_position,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [cdpc_pkg::DataW-1:0]          o_corrected_position
);

    logic                       r_capture_mode;
    logic [cdpc_pkg::DataW-1:0] r_period;
    logic [cdpc_pkg::DataW-1:0] r_buffer;
    logic [cdpc_pkg::FifoW-1:0] r_fifo;
    cdpc_pkg::t_reg_idx         reg_idx;
    logic                       wr_en;
    cdpc_pkg::t_cmd             cmd;
    cdpc_pkg::t_sts             sts;

    assign pready  = 1'b1;
    assign reg_idx = cdpc_pkg::t_reg_idx'(paddr[cdpc_pkg::AddrW-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture_mode <= 1'b0;
            r_period       <= cdpc_pkg::RstPeriod;
            r_buffer       <= cdpc_pkg::RstBuffer;
            r_fifo         <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                cdpc_pkg::REG_MODE:   r_capture_mode <= pwdata[0];
                cdpc_pkg::REG_PERIOD: r_period       <= pwdata;
                cdpc_pkg::REG_BUFFER: r_buffer       <= pwdata;
                cdpc_pkg::REG_FIFO:   r_fifo         <= pwdata[cdpc_pkg::FifoW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            cdpc_pkg::REG_MODE:   prdata = {{(cdpc_pkg::DataW-1){1'b0}}, r_capture_mode};
            cdpc_pkg::REG_PERIOD: prdata = r_period;
            cdpc_pkg::REG_BUFFER: prdata = r_buffer;
            cdpc_pkg::REG_FIFO:
                prdata = {{(cdpc_pkg::DataW-cdpc_pkg::FifoW){1'b0}}, r_fifo};
            default:              prdata = '0;
        endcase
    end

    cdpc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_capture_mode (r_capture_mode),
        .i_in_valid     (i_in_valid),
        .i_sts          (sts),
        .o_in_stall     (o_in_stall),
        .o_cmd          (cmd)
    );

    cdpc_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_period             (r_period),
        .i_buffer             (r_buffer),
        .i_fifo               (r_fifo),
        .i_link_position      (i_link_position),
        .i_dma_position       (i_dma_position),
        .i_out_stall          (i_out_stall),
        .o_sts                (sts),
        .o_out_valid          (o_out_valid),
        .o_corrected_position (o_corrected_position)
    );

    `ASSERT_NEXT(a_accept_busy, i_in_valid && !o_in_stall, o_in_stall, "accept did not go busy")
    `ASSERT_IMP(a_div_idle_start, cmd.div_start, !sts.div_busy, "remainder restarted while busy")
    `ASSERT_IMP(a_cap_on_done, cmd.cap != cdpc_pkg::DV_NONE, sts.div_done, "capture without done")
    `ASSERT_IMP(a_out_no_overrun, cmd.out_load, !o_out_valid || !i_out_stall, "result overrun")

endmodule

### tb/sv/capture_dma_position_correction_top_tb.sv
// Testbench for capture_dma_position_correction_top: directed and random queries
// checked against an in-bench predictor of the corrected stream position.
// Depends on cdpc_pkg and the RTL under src/.
module capture_dma_position_correction_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cdpc_pkg::*;

    localparam int QuietLimit = 2000;
    localparam int DrainCycles = 60;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [DataW-1:0] pwdata = '0;
    logic [DataW-1:0] prdata;
    logic pready;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [DataW-1:0] i_link_position = '0;
    logic [DataW-1:0] i_dma_position = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [DataW-1:0] o_corrected_position;

    // shadow of the block's registers and start-up flag
    logic cfg_capture = 1'b0;
    logic [DataW-1:0] cfg_period = RstPeriod;
    logic [DataW-1:0] cfg_buffer = RstBuffer;
    logic [FifoW-1:0] cfg_fifo = '0;
    logic startup_pending = 1'b1;

    logic [DataW-1:0] expected_positions[$];
    int mismatches = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    logic idle_on = 1'b1;

    capture_dma_position_correction_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_link_position(i_link_position),
        .i_dma_position(i_dma_position),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_corrected_position(o_corrected_position)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [DataW-1:0] rem_or_pass(logic [DataW-1:0] x, logic [DataW-1:0] d);
        return (d == '0) ? x : x % d;
    endfunction

    function automatic logic [DataW-1:0] predict_position(logic [DataW-1:0] link,
                                                          logic [DataW-1:0] dma);
        logic [DataW-1:0] fifo32, dma_off, adj, adj_off, link_off, bound;
        if (!cfg_capture) begin
            return link;
        end
        fifo32 = {{(DataW-FifoW){1'b0}}, cfg_fifo};
        dma_off = rem_or_pass(dma, cfg_period);
        if (startup_pending) begin
            if (link <= fifo32) begin
                return '0;
            end
            startup_pending = 1'b0;
        end
        if (link <= fifo32) begin
            adj = cfg_buffer + link - fifo32;
        end else begin
            adj = link - fifo32;
        end
        adj_off = rem_or_pass(adj, cfg_period);
        link_off = rem_or_pass(link, cfg_period);
        if (link_off >= fifo32) begin
            bound = link - link_off;
        end else if (dma_off >= adj_off) begin
            bound = adj - adj_off;
        end else begin
            bound = adj - adj_off + cfg_period;
            if (bound >= cfg_buffer) begin
                bound = '0;
            end
        end
        return bound + dma_off;
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [DataW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) begin
            @(posedge i_clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MODE:   cfg_capture = value[0];
            REG_PERIOD: cfg_period = value;
            REG_BUFFER: cfg_buffer = value;
            REG_FIFO:   cfg_fifo = value[FifoW-1:0];
            default:    ;
        endcase
    endtask

    task automatic send_query(input logic [DataW-1:0] link, input logic [DataW-1:0] dma);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_link_position <= link;
        i_dma_position <= dma;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) begin
            @(posedge i_clk);
        end
        expected_positions.push_back(predict_position(link, dma));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_positions.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_playback_defaults();
        send_query('0, '0);
        send_query('1, '1);
        send_query(32'hAAAA_5555, 32'h5555_AAAA);
        send_query(32'h5555_AAAA, 32'hAAAA_5555);
    endtask

    task automatic test_capture_startup();
        drain_results();
        write_reg(REG_FIFO, 32'd64);
        write_reg(REG_MODE, 32'd1);
        send_query(32'd0, 32'd77);
        send_query(32'd64, '1);
        send_query(32'd10, 32'd5000);
        drain_results();
        // playback leaves the start-up flag alone
        write_reg(REG_MODE, 32'd0);
        send_query(32'd5, 32'd9);
        drain_results();
        write_reg(REG_MODE, 32'd1);
        send_query(32'd3, 32'd9);
        send_query(32'd65, 32'd4100);
        send_query(32'd3, 32'd9);
    endtask

    task automatic test_capture_corners();
        drain_results();
        write_reg(REG_FIFO, 32'd256);
        send_query(32'd5000, 32'h0001_2345);
        send_query(32'd8202, 32'd4000);
        send_query(32'd8202, 32'd1);
        send_query(32'd100, 32'd5);
        send_query('1, '1);
        drain_results();
        write_reg(REG_PERIOD, '0);
        send_query(32'd300, 32'd7);
        send_query(32'd10, '1);
        drain_results();
        write_reg(REG_PERIOD, '1);
        write_reg(REG_BUFFER, '1);
        write_reg(REG_FIFO, 32'hFFFF_FFFF);
        send_query('0, '0);
        send_query(32'h0000_FFFF, 32'hFFFF_FFFE);
        send_query('1, 32'd12);
        drain_results();
        write_reg(REG_PERIOD, 32'd1);
        write_reg(REG_BUFFER, 32'd1);
        write_reg(REG_FIFO, 32'hFFFF_0000);
        send_query('0, '0);
        send_query(32'd123, 32'd456);
    endtask

    task automatic test_random_phases();
        int phase, n;
        logic mode;
        logic [DataW-1:0] per_bytes, ring_bytes, link, dma;
        logic [FifoW-1:0] fifo_bytes;
        for (phase = 0; phase < 9; phase++) begin
            drain_results();
            idle_on = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            mode = (phase != 3);
            case (phase)
                0: begin
                    per_bytes = '0;
                    ring_bytes = 32'd65536;
                    fifo_bytes = 16'd512;
                end
                1: begin
                    per_bytes = 32'd1;
                    ring_bytes = '1;
                    fifo_bytes = '1;
                end
                2: begin
                    per_bytes = '1;
                    ring_bytes = 32'd1;
                    fifo_bytes = '0;
                end
                default: begin
                    per_bytes = 32'd1 << $urandom_range(2, 14);
                    ring_bytes = per_bytes * $urandom_range(1, 32);
                    fifo_bytes = FifoW'($urandom_range(0, 1023));
                end
            endcase
            if (phase >= 5 && phase[0]) begin
                per_bytes = $urandom_range(3, 5000);
            end
            write_reg(REG_MODE, ($urandom & 32'hFFFF_FFFE) | mode);
            write_reg(REG_PERIOD, per_bytes);
            write_reg(REG_BUFFER, ring_bytes);
            write_reg(REG_FIFO, ($urandom << FifoW) | fifo_bytes);
            for (n = 0; n < 100; n++) begin
                case ($urandom_range(0, 3))
                    0: link = $urandom;
                    1: link = {16'd0, cfg_fifo} + $urandom_range(0, 64) - 32;
                    2: link = cfg_buffer + $urandom_range(0, 64) - 32;
                    default: link = cfg_period * $urandom_range(0, 40)
                                    + $urandom_range(0, cfg_fifo);
                endcase
                dma = $urandom_range(0, 1) ? $urandom : $urandom_range(0, cfg_period);
                send_query(link, dma);
                if ($urandom_range(0, 49) == 0) begin
                    drain_results();
                end
            end
        end
        idle_on = 1'b1;
    endtask

    // result check and output stall
    always @(posedge i_clk) begin
        logic [DataW-1:0] want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_positions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected item: corrected_position %h", o_corrected_position);
                end
            end else begin
                want = expected_positions.pop_front();
                if (o_corrected_position !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("corrected_position: expected %h, actual %h",
                                 want, o_corrected_position);
                    end
                end
            end
            stall_left = idle_on ? $urandom_range(0, 3) : 0;
            i_out_stall <= (stall_left > 0);
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= (stall_left > 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)
                || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QuietLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_playback_defaults();
        test_capture_startup();
        test_capture_corners();
        test_random_phases();
        drain_results();
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/cdpc_pkg.sv
src/cdpc_rem.sv
src/cdpc_dp.sv
src/cdpc_ctrl.sv
src/capture_dma_position_correction_top.sv
tb/sv/capture_dma_position_correction_top_tb.sv
